[rtl/stream_find_replace_macros.svh]
// ----------------------------------------------------------------------------
// stream_find_replace assertion macros
// Clocked assertion wrappers for the find-and-replace RTL.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define SFR_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define SFR_ASSERT(lbl, prop, msg)
`define SFR_NEVER(lbl, expr, msg)
`endif

`endif

[rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int USER_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES = 8'd0,
        CFG_PATTERN_LEN   = 8'd1,
        CFG_REPLACE_BYTES = 8'd2,
        CFG_REPLACE_LEN   = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              found;
        logic              last;
        logic              valid;
        logic [BYTE_W-1:0] data;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic shift;
    } out_ctl_t;

endpackage

[rtl/stream_find_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace-all over a byte stream.
//
//   Channel | Dir | Handshake          | Payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata = byte, s_tlast = end of text
//   m_      | out | m_tvalid/m_tready  | m_tdata = byte, m_tuser = flags, m_tlast
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One input word per cycle while each word yields at most one output word and m_tready does not stall the output.
// A word that yields k output words loads all k into the output chain at once;
// the input register refills once the chain has room for its results.
// An accepted word is held in the input register, then loaded into the output chain.
// Reset clears control and configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "stream_find_replace_macros.svh"

module stream_find_replace #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] in_byte
    input  logic                             s_tlast,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]       m_tdata,   // [7:0] out_byte
    output logic [sfr_pkg::USER_W-1:0]       m_tuser,   // [0] byte_valid, [1] found_any
    output logic                             m_tlast,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sfr_pkg::*;

    localparam int OUT_DEPTH = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    localparam int WIN       = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int CNT_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
    localparam int PAT_W     = BYTE_W * PATTERN_MAX;
    localparam int REP_W     = BYTE_W * REPLACE_MAX;

    // configuration
    logic [PAT_W-1:0]  pattern_reg, pattern_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [REP_W-1:0]  replace_reg, replace_next;
    logic [LEN_W-1:0]  rlen_reg, rlen_next;
    logic [LEN_W-1:0]  cfg_len;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg, in_byte_next;
    logic              in_last_reg, in_last_next;

    // window state
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              matched_reg, matched_next;

    // output chain state
    logic [OCNT_W-1:0] ocnt_reg, ocnt_next;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_arr;
    logic [OUT_DEPTH-1:0][BYTE_W-1:0]   rep_pad;
    logic [WIN-1:0][BYTE_W-1:0]         win_q;
    logic [WIN-1:0][BYTE_W-1:0]         win_ref;
    logic [WIN-1:0]                     win_active;
    logic [WIN-1:0]                     win_match;
    logic [OUT_DEPTH-1:0][BYTE_W-1:0]   buf_arr;
    out_item_t [OUT_DEPTH-1:0]          list;
    out_item_t [OUT_DEPTH-1:0]          out_q;
    out_item_t [OUT_DEPTH-1:0]          load_item;
    out_ctl_t  [OUT_DEPTH-1:0]          out_ctl;

    logic [LEN_W-1:0]  n1;
    logic              over;
    logic              eq;
    logic              new_match;
    logic              hit;
    logic              matched_hit;
    logic [OCNT_W-1:0] k;
    logic [OCNT_W-1:0] base;
    logic              consume;
    logic              pop;
    logic              s_hs;

    // ---------------- configuration port ----------------
    assign cfg_ready = 1'b1;
    assign cfg_len   = cfg_data[LEN_W-1:0];

    always_comb begin
        pattern_next = pattern_reg;
        plen_next    = plen_reg;
        replace_next = replace_reg;
        rlen_next    = rlen_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES: begin
                    pattern_next = cfg_data[PAT_W-1:0];
                end
                CFG_PATTERN_LEN: begin
                    if (cfg_len == '0) begin
                        plen_next = LEN_W'(1);
                    end else if (cfg_len > LEN_W'(PATTERN_MAX)) begin
                        plen_next = LEN_W'(PATTERN_MAX);
                    end else begin
                        plen_next = cfg_len;
                    end
                end
                CFG_REPLACE_BYTES: begin
                    replace_next = cfg_data[REP_W-1:0];
                end
                CFG_REPLACE_LEN: begin
                    if (cfg_len > LEN_W'(REPLACE_MAX)) begin
                        rlen_next = LEN_W'(REPLACE_MAX);
                    end else begin
                        rlen_next = cfg_len;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- match decision ----------------
    assign pat_arr = pattern_reg;
    assign rep_pad = (BYTE_W * OUT_DEPTH)'(replace_reg);

    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            win_active[j] = j < int'(cnt_reg);
            win_ref[j]    = '0;
            for (int p = 0; p < PATTERN_MAX; p++) begin
                if (p + j + 1 == int'(cnt_reg)) begin
                    win_ref[j] = pat_arr[p];
                end
            end
        end
    end

    assign n1          = LEN_W'(cnt_reg) + LEN_W'(1);
    assign over        = n1 > plen_reg;
    assign eq          = n1 == plen_reg;
    assign new_match   = in_byte_reg == pat_arr[cnt_reg];
    assign hit         = eq && new_match && (&win_match);
    assign matched_hit = matched_reg || hit;

    always_comb begin
        if (hit) begin
            k = (in_last_reg && rlen_reg == '0) ? OCNT_W'(1) : OCNT_W'(rlen_reg);
        end else if (in_last_reg) begin
            k = OCNT_W'(n1);
        end else begin
            k = (over || eq) ? OCNT_W'(1) : '0;
        end
    end

    // window bytes plus the new byte, oldest first
    always_comb begin
        for (int i = 0; i < OUT_DEPTH; i++) begin
            buf_arr[i] = '0;
            if (i == int'(cnt_reg)) begin
                buf_arr[i] = in_byte_reg;
            end
            for (int j = 0; j < WIN; j++) begin
                if (i + j + 1 == int'(cnt_reg)) begin
                    buf_arr[i] = win_q[j];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < OUT_DEPTH; i++) begin
            list[i].valid = !(hit && rlen_reg == '0);
            list[i].data  = '0;
            if (list[i].valid) begin
                list[i].data = hit ? rep_pad[i] : buf_arr[i];
            end
            list[i].last  = in_last_reg && (i + 1 == int'(k));
            list[i].found = list[i].last && matched_hit;
        end
    end

    // ---------------- handshakes ----------------
    assign m_tvalid = ocnt_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign consume  = in_valid_reg &&
                      ((OCNT_W + 1)'(ocnt_reg) + (OCNT_W + 1)'(k) <= (OCNT_W + 1)'(OUT_DEPTH));
    assign s_tready = !in_valid_reg || consume;
    assign s_hs     = s_tvalid && s_tready;
    assign base     = ocnt_reg - OCNT_W'(pop);

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (s_hs) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        cnt_next     = cnt_reg;
        matched_next = matched_reg;
        if (consume) begin
            if (in_last_reg || hit) begin
                cnt_next = '0;
            end else if (!(over || eq)) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            matched_next = in_last_reg ? 1'b0 : matched_hit;
        end
    end

    always_comb begin
        ocnt_next = ocnt_reg - OCNT_W'(pop) + (consume ? k : '0);
    end

    always_comb begin
        for (int j = 0; j < OUT_DEPTH; j++) begin
            out_ctl[j].shift = pop;
            out_ctl[j].load  = 1'b0;
            load_item[j]     = '0;
            for (int i = 0; i < OUT_DEPTH; i++) begin
                if (consume && i < int'(k) && i + int'(base) == j) begin
                    out_ctl[j].load = 1'b1;
                    load_item[j]    = list[i];
                end
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg  <= '0;
            plen_reg     <= LEN_W'(1);
            replace_reg  <= '0;
            rlen_reg     <= '0;
            in_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            matched_reg  <= 1'b0;
            ocnt_reg     <= '0;
        end else begin
            pattern_reg  <= pattern_next;
            plen_reg     <= plen_next;
            replace_reg  <= replace_next;
            rlen_reg     <= rlen_next;
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            matched_reg  <= matched_next;
            ocnt_reg     <= ocnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
    end

    // ---------------- cell chains ----------------
    for (genvar j = 0; j < WIN; j++) begin : g_win
        logic [BYTE_W-1:0] d_in;
        if (j == 0) begin : g_head
            assign d_in = in_byte_reg;
        end else begin : g_tail
            assign d_in = win_q[j-1];
        end
        sfr_win_cell u_cell (
            .aclk     (aclk),
            .shift_en (consume),
            .d_in     (d_in),
            .ref_byte (win_ref[j]),
            .active   (win_active[j]),
            .q        (win_q[j]),
            .match    (win_match[j])
        );
    end

    for (genvar j = 0; j < OUT_DEPTH; j++) begin : g_out
        out_item_t shift_item;
        if (j < OUT_DEPTH - 1) begin : g_mid
            assign shift_item = out_q[j+1];
        end else begin : g_end
            assign shift_item = '0;
        end
        sfr_out_cell u_cell (
            .aclk       (aclk),
            .ctl        (out_ctl[j]),
            .load_item  (load_item[j]),
            .shift_item (shift_item),
            .q          (out_q[j])
        );
    end

    assign m_tdata = out_q[0].data;
    assign m_tuser = {out_q[0].found, out_q[0].valid};
    assign m_tlast = out_q[0].last;

    // ---------------- assertions ----------------
    `SFR_ASSERT(a_last_clears, consume && in_last_reg |=> (cnt_reg == '0) && !matched_reg, "window not cleared after last word")
    `SFR_ASSERT(a_hit_marks, consume && hit && !in_last_reg |=> matched_reg, "match not recorded")
    `SFR_NEVER(a_out_bound, ocnt_reg > OCNT_W'(OUT_DEPTH), "output chain overfilled")
    `SFR_NEVER(a_found_last, m_tvalid && m_tuser[1] && !m_tlast, "found flag without last")

endmodule

[rtl/sfr_win_cell.sv]
// ----------------------------------------------------------------------------
// sfr_win_cell
// One byte of the pending window: shifts toward older positions and
// compares its byte against the pattern byte chosen for its position.
// ----------------------------------------------------------------------------
module sfr_win_cell (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic [sfr_pkg::BYTE_W-1:0]  d_in,
    input  logic [sfr_pkg::BYTE_W-1:0]  ref_byte,
    input  logic                        active,
    output logic [sfr_pkg::BYTE_W-1:0]  q,
    output logic                        match
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = shift_en ? d_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign q     = byte_reg;
    assign match = !active || (byte_reg == ref_byte);

endmodule

[rtl/sfr_out_cell.sv]
// ----------------------------------------------------------------------------
// sfr_out_cell
// One slot of the output chain: takes a new result, else its neighbor's word on a shift, else holds.
// ----------------------------------------------------------------------------
module sfr_out_cell (
    input  logic                aclk,
    input  sfr_pkg::out_ctl_t   ctl,
    input  sfr_pkg::out_item_t  load_item,
    input  sfr_pkg::out_item_t  shift_item,
    output sfr_pkg::out_item_t  q
);
    import sfr_pkg::*;

    out_item_t item_reg;
    out_item_t item_next;

    always_comb begin
        if (ctl.load) begin
            item_next = load_item;
        end else if (ctl.shift) begin
            item_next = shift_item;
        end else begin
            item_next = item_reg;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign q = item_reg;

endmodule
